FILE: hw/rtl/vpbs_pkg.sv
// ----------------------------------------------------------------------------
// vpbs_pkg
// Shared types and register indexes for the bounded point integrator.
// ----------------------------------------------------------------------------
package vpbs_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_FRICTION = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BOUNCE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GRAVITY  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HEIGHT   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PINNED   = 3'd5;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // which product the shared multiplier forms this cycle
  typedef enum logic [1:0] {
    MUL_FRIC_X = 2'd0,
    MUL_FRIC_Y = 2'd1,
    MUL_BNC_X  = 2'd2,
    MUL_BNC_Y  = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load;     // capture the accepted item
    logic     mul_en;   // write the selected product
    mul_sel_t mul_sel;
    logic     commit;   // update the point and load the result registers
  } dp_cmd_t;

  typedef struct packed {
    logic pinned;
  } dp_status_t;

endpackage

FILE: hw/rtl/vpbs_ctrl.sv
// ----------------------------------------------------------------------------
// vpbs_ctrl
// Sequencer for the integrator: orders the four shared multiplies of a step
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module vpbs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  vpbs_pkg::dp_status_t status,
  output vpbs_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FRIC_X = 6'b000010,
    S_FRIC_Y = 6'b000100,
    S_BNC_X  = 6'b001000,
    S_BNC_Y  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.load      = 1'b0;
    cmd.mul_en    = 1'b0;
    cmd.mul_sel   = vpbs_pkg::MUL_FRIC_X;
    cmd.commit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          // set commands and pinned steps need no multiply
          if (in_command == vpbs_pkg::CMD_STEP && !status.pinned) begin
            state_nxt = S_FRIC_X;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_FRIC_X: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = vpbs_pkg::MUL_FRIC_X;
        state_nxt   = S_FRIC_Y;
      end
      S_FRIC_Y: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = vpbs_pkg::MUL_FRIC_Y;
        state_nxt   = S_BNC_X;
      end
      S_BNC_X: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = vpbs_pkg::MUL_BNC_X;
        state_nxt   = S_BNC_Y;
      end
      S_BNC_Y: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = vpbs_pkg::MUL_BNC_Y;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/vpbs_dp.sv
// ----------------------------------------------------------------------------
// vpbs_dp
// Datapath: configuration registers, point state, one shared Q16.16 by
// unsigned Q1.16 multiplier, wall clamp and saturating update.
// ----------------------------------------------------------------------------
module vpbs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vpbs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_command,
  input  logic signed [31:0]            in_new_pos_x,
  input  logic signed [31:0]            in_new_pos_y,
  input  logic signed [31:0]            in_start_vel_x,
  input  logic signed [31:0]            in_start_vel_y,
  input  vpbs_pkg::dp_cmd_t             cmd,
  output vpbs_pkg::dp_status_t          status,
  output logic signed [31:0]            out_pos_x,
  output logic signed [31:0]            out_pos_y,
  output logic signed [31:0]            out_vel_x,
  output logic signed [31:0]            out_vel_y
);

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -33'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // clamp one coordinate into 0..size and pick the bounced velocity where it
  // still heads outwards; returns {position, velocity}
  function automatic logic [63:0] wall(input logic signed [31:0] pos,
                                       input logic signed [31:0] vf,
                                       input logic signed [31:0] vb,
                                       input logic [15:0]        size);
    logic signed [32:0] edge_s;
    logic signed [31:0] np;
    logic signed [31:0] nv;
    edge_s = $signed({1'b0, size, 16'h0000});
    np     = pos;
    nv     = vf;
    if (pos < 0) begin
      np = '0;
      if (vf < 0) begin
        nv = vb;
      end
    end else if ($signed({pos[31], pos}) > edge_s) begin
      np = edge_s[31:0];
      if (vf > 0) begin
        nv = vb;
      end
    end
    return {np, nv};
  endfunction

  logic [16:0]        friction_r;
  logic [16:0]        bounce_r;
  logic signed [31:0] gravity_r;
  logic [15:0]        width_r;
  logic [15:0]        height_r;
  logic               pinned_r;

  logic signed [31:0] cur_x_r, cur_y_r, prev_x_r, prev_y_r;
  logic               cmd_r;
  logic signed [31:0] in_px_r, in_py_r, in_vx_r, in_vy_r;
  logic signed [31:0] vfx_r, vfy_r, vbx_r, vby_r;
  logic signed [31:0] opx_r, opy_r, ovx_r, ovy_r;

  logic signed [32:0] mul_a;
  logic [16:0]        mul_g;
  logic signed [50:0] prod;
  logic signed [31:0] scaled;

  logic [63:0]        wall_x, wall_y;
  logic signed [31:0] npx, npy, nvx, nvy;
  logic signed [31:0] ny_part;
  logic signed [31:0] cur_x_nxt, cur_y_nxt, prev_x_nxt, prev_y_nxt;
  logic signed [31:0] res_vx, res_vy;

  assign status.pinned = pinned_r;

  always_comb begin
    case (cmd.mul_sel)
      vpbs_pkg::MUL_FRIC_X: begin
        mul_a = $signed({cur_x_r[31], cur_x_r}) - $signed({prev_x_r[31], prev_x_r});
        mul_g = friction_r;
      end
      vpbs_pkg::MUL_FRIC_Y: begin
        mul_a = $signed({cur_y_r[31], cur_y_r}) - $signed({prev_y_r[31], prev_y_r});
        mul_g = friction_r;
      end
      vpbs_pkg::MUL_BNC_X: begin
        mul_a = -$signed({vfx_r[31], vfx_r});
        mul_g = bounce_r;
      end
      vpbs_pkg::MUL_BNC_Y: begin
        mul_a = -$signed({vfy_r[31], vfy_r});
        mul_g = bounce_r;
      end
      default: begin
        mul_a = '0;
        mul_g = '0;
      end
    endcase
  end

  // dropping the low 16 bits of a signed product rounds toward minus infinity
  assign prod   = mul_a * $signed({1'b0, mul_g});
  assign scaled = sat35(prod[50:16]);

  assign wall_x  = wall(cur_x_r, vfx_r, vbx_r, width_r);
  assign wall_y  = wall(cur_y_r, vfy_r, vby_r, height_r);
  assign npx     = wall_x[63:32];
  assign nvx     = wall_x[31:0];
  assign npy     = wall_y[63:32];
  assign nvy     = wall_y[31:0];
  assign ny_part = sat33($signed({npy[31], npy}) + $signed({nvy[31], nvy}));

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    res_vx     = '0;
    res_vy     = '0;
    if (cmd_r == vpbs_pkg::CMD_SET) begin
      cur_x_nxt  = in_px_r;
      cur_y_nxt  = in_py_r;
      prev_x_nxt = sat33($signed({in_px_r[31], in_px_r}) - $signed({in_vx_r[31], in_vx_r}));
      prev_y_nxt = sat33($signed({in_py_r[31], in_py_r}) - $signed({in_vy_r[31], in_vy_r}));
      res_vx     = in_vx_r;
      res_vy     = in_vy_r;
    end else if (!pinned_r) begin
      prev_x_nxt = npx;
      prev_y_nxt = npy;
      cur_x_nxt  = sat33($signed({npx[31], npx}) + $signed({nvx[31], nvx}));
      cur_y_nxt  = sat33($signed({ny_part[31], ny_part}) +
                         $signed({gravity_r[31], gravity_r}));
      res_vx     = nvx;
      res_vy     = nvy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      friction_r <= 17'h10000;
      bounce_r   <= 17'h10000;
      gravity_r  <= '0;
      width_r    <= 16'd640;
      height_r   <= 16'd480;
      pinned_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        vpbs_pkg::CFG_FRICTION: friction_r <= cfg_data[16:0];
        vpbs_pkg::CFG_BOUNCE:   bounce_r   <= cfg_data[16:0];
        vpbs_pkg::CFG_GRAVITY:  gravity_r  <= $signed(cfg_data);
        vpbs_pkg::CFG_WIDTH:    width_r    <= cfg_data[15:0];
        vpbs_pkg::CFG_HEIGHT:   height_r   <= cfg_data[15:0];
        vpbs_pkg::CFG_PINNED:   pinned_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      prev_x_r <= '0;
      prev_y_r <= '0;
    end else if (cmd.commit) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      in_px_r <= in_new_pos_x;
      in_py_r <= in_new_pos_y;
      in_vx_r <= in_start_vel_x;
      in_vy_r <= in_start_vel_y;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        vpbs_pkg::MUL_FRIC_X: vfx_r <= scaled;
        vpbs_pkg::MUL_FRIC_Y: vfy_r <= scaled;
        vpbs_pkg::MUL_BNC_X:  vbx_r <= scaled;
        vpbs_pkg::MUL_BNC_Y:  vby_r <= scaled;
        default: begin
        end
      endcase
    end
    if (cmd.commit) begin
      opx_r <= cur_x_nxt;
      opy_r <= cur_y_nxt;
      ovx_r <= res_vx;
      ovy_r <= res_vy;
    end
  end

  assign out_pos_x = opx_r;
  assign out_pos_y = opy_r;
  assign out_vel_x = ovx_r;
  assign out_vel_y = ovy_r;

endmodule

FILE: hw/rtl/verlet_point_bounded_step.sv
// ----------------------------------------------------------------------------
// verlet_point_bounded_step
// Position Verlet integrator for one point with wall clamp and bounce.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write channel, index selects friction, bounce, gravity, width,
//            height or pinned; always ready, write only while no item is open
//   in_*   : one item per command, 0 loads position and velocity, 1 steps
//   out_*  : one result item per input item, held in an output register
// Sequencing: a set command or a pinned step goes from acceptance straight
//   to the done state; a full step first runs the four multiplies (friction
//   x and y, bounce x and y) in turn through the one shared multiplier.
// Throughput: one item at a time.
//   A new item is taken while the previous result still waits.
// Stall: when the receiver holds out_ready low, the finished item waits in
//   the sequencer's last state until the output register is free.
// Reset: synchronous, active low; point state clears to zero and the
//   registers return to unity gains, no gravity, a 640 by 480 area, unpinned.
// ----------------------------------------------------------------------------
module verlet_point_bounded_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vpbs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic signed [31:0]            in_new_pos_x,
  input  logic signed [31:0]            in_new_pos_y,
  input  logic signed [31:0]            in_start_vel_x,
  input  logic signed [31:0]            in_start_vel_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_pos_x,
  output logic signed [31:0]            out_pos_y,
  output logic signed [31:0]            out_vel_x,
  output logic signed [31:0]            out_vel_y
);

  vpbs_pkg::dp_cmd_t    ctl_cmd;
  vpbs_pkg::dp_status_t dp_status;

  assign cfg_ready = 1'b1;

  vpbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (dp_status),
    .cmd        (ctl_cmd)
  );

  vpbs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_command),
    .in_new_pos_x   (in_new_pos_x),
    .in_new_pos_y   (in_new_pos_y),
    .in_start_vel_x (in_start_vel_x),
    .in_start_vel_y (in_start_vel_y),
    .cmd            (ctl_cmd),
    .status         (dp_status),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_vel_x      (out_vel_x),
    .out_vel_y      (out_vel_y)
  );

  // one item at a time: no second acceptance straight after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.commit |=> out_valid)
    else $error("committed item not presented");

  // the multiplier is only busy while no item can enter
  a_mul_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.mul_en |-> !in_ready)
    else $error("multiply while idle");

endmodule

FILE: bench/tb_verlet_point_bounded_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_verlet_point_bounded_step
// Self-checking bench for the bounded point integrator: a short directed
// table (extremes, wall clamp and bounce, saturation, pinned point) and then
// random set/step sequences under random register settings and random idle on
// both channels, each result checked against its table row or a local model.
// ----------------------------------------------------------------------------
module tb_verlet_point_bounded_step;

  localparam logic [31:0] S32_MAX_V = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN_V = 32'h8000_0000;
  localparam logic [vpbs_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [vpbs_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
  } point_res_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic                         cmd;
    logic [31:0]                  px, py, vx, vy;
    logic [vpbs_pkg::CfgIdxW-1:0] reg_idx;
    logic [31:0]                  reg_val;
    logic                         typed;
    point_res_t                   exp;
  } plan_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [vpbs_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [31:0]                  cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_command = vpbs_pkg::CMD_SET;
  logic signed [31:0]           in_new_pos_x = '0;
  logic signed [31:0]           in_new_pos_y = '0;
  logic signed [31:0]           in_start_vel_x = '0;
  logic signed [31:0]           in_start_vel_y = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [31:0]           out_pos_x, out_pos_y, out_vel_x, out_vel_y;

  verlet_point_bounded_step dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_new_pos_x   (in_new_pos_x),
    .in_new_pos_y   (in_new_pos_y),
    .in_start_vel_x (in_start_vel_x),
    .in_start_vel_y (in_start_vel_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_vel_x      (out_vel_x),
    .out_vel_y      (out_vel_y)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("verlet_point_bounded_step regression: fail");
    $finish;
  end

  // point model: registers and state
  logic [16:0]        fric_q, bnc_q;
  logic signed [31:0] grav_q;
  logic [15:0]        span_w, span_h;
  logic               pin_q;
  longint             pt_x, pt_y, pt_prev_x, pt_prev_y;

  point_res_t expected_q[$];
  int         mismatches = 0;
  int         in_gap_max = 0;
  int         out_stall_max = 0;
  logic       row_typed = 1'b0;
  point_res_t row_exp = '0;
  plan_row_t  plan_q[$];

  function automatic void reset_model();
    fric_q = 17'd65536;
    bnc_q = 17'd65536;
    grav_q = '0;
    span_w = 16'd640;
    span_h = 16'd480;
    pin_q = 1'b0;
    pt_x = 0;
    pt_y = 0;
    pt_prev_x = 0;
    pt_prev_y = 0;
  endfunction

  function automatic void apply_reg(logic [vpbs_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    case (idx)
      vpbs_pkg::CFG_FRICTION: fric_q = val[16:0];
      vpbs_pkg::CFG_BOUNCE:   bnc_q = val[16:0];
      vpbs_pkg::CFG_GRAVITY:  grav_q = val;
      vpbs_pkg::CFG_WIDTH:    span_w = val[15:0];
      vpbs_pkg::CFG_HEIGHT:   span_h = val[15:0];
      vpbs_pkg::CFG_PINNED:   pin_q = val[0];
      default: ;
    endcase
  endfunction

  function automatic longint sat32(longint v);
    if (v > longint'($signed(S32_MAX_V))) return longint'($signed(S32_MAX_V));
    if (v < longint'($signed(S32_MIN_V))) return longint'($signed(S32_MIN_V));
    return v;
  endfunction

  // arithmetic shift floors, as the block rounds toward minus infinity
  function automatic longint scale_gain(longint p);
    return sat32(p >>> 16);
  endfunction

  function automatic void bound_axis(inout longint pos, inout longint vel,
                                     input logic [15:0] size);
    longint wall;
    wall = longint'(size) * 65536;
    if (pos < 0) begin
      pos = 0;
      if (vel < 0) vel = scale_gain(-vel * longint'(bnc_q));
    end
    if (pos > wall) begin
      pos = wall;
      if (vel > 0) vel = scale_gain(-vel * longint'(bnc_q));
    end
  endfunction

  function automatic point_res_t advance_point(logic cmd, logic [31:0] px, logic [31:0] py,
                                               logic [31:0] vx_in, logic [31:0] vy_in);
    longint     vx, vy;
    point_res_t r;
    vx = 0;
    vy = 0;
    if (cmd == vpbs_pkg::CMD_SET) begin
      vx = longint'($signed(vx_in));
      vy = longint'($signed(vy_in));
      pt_x = longint'($signed(px));
      pt_y = longint'($signed(py));
      pt_prev_x = sat32(pt_x - vx);
      pt_prev_y = sat32(pt_y - vy);
    end else if (!pin_q) begin
      vx = scale_gain((pt_x - pt_prev_x) * longint'(fric_q));
      vy = scale_gain((pt_y - pt_prev_y) * longint'(fric_q));
      bound_axis(pt_x, vx, span_w);
      bound_axis(pt_y, vy, span_h);
      pt_prev_x = pt_x;
      pt_prev_y = pt_y;
      pt_x = sat32(pt_x + vx);
      pt_y = sat32(sat32(pt_y + vy) + longint'(grav_q));
    end
    r.pos_x = pt_x[31:0];
    r.pos_y = pt_y[31:0];
    r.vel_x = vx[31:0];
    r.vel_y = vy[31:0];
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // results checked before new items are predicted, all at the rising edge
  always @(posedge clk) begin
    point_res_t want, got;
    if (!rst_n) begin
      reset_model();
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected item expected none got %h %h %h %h", $time,
                   out_pos_x, out_pos_y, out_vel_x, out_vel_y);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_pos_x", want.pos_x, out_pos_x);
          check_field("out_pos_y", want.pos_y, out_pos_y);
          check_field("out_vel_x", want.vel_x, out_vel_x);
          check_field("out_vel_y", want.vel_y, out_vel_y);
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        got = advance_point(in_command, in_new_pos_x, in_new_pos_y,
                            in_start_vel_x, in_start_vel_y);
        expected_q.push_back(row_typed ? row_exp : got);
      end
    end
  end

  // result side: random hold-off per item
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      k = $urandom_range(0, out_stall_max);
      @(negedge clk);
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic push_item(logic cmd, logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                           logic [31:0] vy, logic typed, point_res_t exp);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_new_pos_x <= px;
    in_new_pos_y <= py;
    in_start_vel_x <= vx;
    in_start_vel_y <= vy;
    row_typed <= typed;
    row_exp <= exp;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender holds off until every result is back and the sequencer has settled
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [vpbs_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_set(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                                  logic [31:0] vy);
    plan_row_t r;
    r = '{kind: ROW_ITEM, cmd: vpbs_pkg::CMD_SET, px: px, py: py, vx: vx, vy: vy,
          reg_idx: '0, reg_val: '0, typed: 1'b1, exp: '{px, py, vx, vy}};
    plan_q.push_back(r);
  endfunction

  function automatic void add_step(logic typed, point_res_t exp);
    plan_row_t r;
    r = '{kind: ROW_ITEM, cmd: vpbs_pkg::CMD_STEP, px: $urandom, py: $urandom,
          vx: $urandom, vy: $urandom, reg_idx: '0, reg_val: '0, typed: typed, exp: exp};
    plan_q.push_back(r);
  endfunction

  function automatic void add_reg(logic [vpbs_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    plan_row_t r;
    r = '{kind: ROW_REG, cmd: vpbs_pkg::CMD_SET, px: '0, py: '0, vx: '0, vy: '0,
          reg_idx: idx, reg_val: val, typed: 1'b0, exp: '0};
    plan_q.push_back(r);
  endfunction

  function automatic logic [31:0] rand_coord(logic [15:0] size);
    longint v;
    case ($urandom_range(0, 9))
      0: v = longint'($signed(S32_MIN_V));
      1: v = longint'($signed(S32_MAX_V));
      2: v = longint'($urandom);
      3: v = -longint'($urandom_range(1, 50 * 65536));
      4: v = (longint'(size) + $urandom_range(0, 50)) * 65536 + $urandom_range(0, 65535);
      default: v = longint'($urandom_range(0, size)) * 65536 + $urandom_range(0, 65535);
    endcase
    return v[31:0];
  endfunction

  function automatic logic [31:0] rand_vel();
    longint v;
    case ($urandom_range(0, 9))
      0: v = longint'($signed(S32_MIN_V));
      1: v = longint'($signed(S32_MAX_V));
      2: v = longint'($urandom);
      3: v = 0;
      default: v = longint'($urandom_range(0, 40 * 65536)) - 20 * 65536;
    endcase
    return v[31:0];
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd131071;
      2: return $urandom;
      3, 4: return 32'd65536;
      default: return $urandom_range(50000, 65536);
    endcase
  endfunction

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'd65535;
      2: return $urandom;
      3: return 32'd640;
      default: return $urandom_range(1, 800);
    endcase
  endfunction

  function automatic logic [31:0] pick_gravity();
    longint v;
    case ($urandom_range(0, 6))
      0: v = 0;
      1: v = longint'($signed(S32_MIN_V));
      2: v = longint'($signed(S32_MAX_V));
      3: v = longint'($urandom);
      default: v = longint'($urandom_range(0, 32768)) - 16384;
    endcase
    return v[31:0];
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 6;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  initial begin
    plan_row_t  row;
    int         total, n, sent, k;
    logic       pin;

    // directed table, reset settings first: unity gains, 640 by 480, no gravity
    add_step(1'b1, '0);
    add_set(32'h000A_0000, 32'h0014_0000, 32'h0001_8000, 32'hFFFE_0000);
    add_step(1'b1, '{32'h000B_8000, 32'h0012_0000, 32'h0001_8000, 32'hFFFE_0000});
    add_set(S32_MAX_V, S32_MIN_V, S32_MIN_V, S32_MAX_V);
    // saturated previous position gives zero velocity, both axes clamped
    add_step(1'b1, '{32'h0280_0000, 32'h0000_0000, 32'h0, 32'h0});
    add_set(32'hFFFB_0000, 32'h0064_0000, 32'hFFFD_0000, 32'h0);
    add_step(1'b0, '0);
    add_set(32'h02BC_0000, 32'h01F4_0000, 32'h0004_0000, 32'h0002_0000);
    add_step(1'b0, '0);
    add_set(S32_MIN_V, S32_MAX_V, S32_MAX_V, S32_MIN_V);
    add_step(1'b0, '0);
    add_set(32'h0, 32'h0, S32_MIN_V, S32_MIN_V);
    add_step(1'b0, '0);
    add_step(1'b0, '0);
    // gains above unity and extreme gravity
    add_reg(vpbs_pkg::CFG_FRICTION, 32'd131071);
    add_reg(vpbs_pkg::CFG_BOUNCE, 32'd131071);
    add_reg(vpbs_pkg::CFG_GRAVITY, S32_MAX_V);
    add_set(32'h0064_0000, 32'h0064_0000, S32_MAX_V, S32_MIN_V);
    add_step(1'b0, '0);
    add_step(1'b0, '0);
    // zero gains, zero width area
    add_reg(vpbs_pkg::CFG_FRICTION, 32'd0);
    add_reg(vpbs_pkg::CFG_BOUNCE, 32'd0);
    add_reg(vpbs_pkg::CFG_GRAVITY, S32_MIN_V);
    add_reg(vpbs_pkg::CFG_WIDTH, 32'd0);
    add_reg(vpbs_pkg::CFG_HEIGHT, 32'd65535);
    add_set(32'h0005_0000, 32'h0005_0000, 32'h0001_0000, 32'h0001_0000);
    add_step(1'b0, '0);
    // pinned point: step keeps position and reports zero velocity
    add_reg(vpbs_pkg::CFG_PINNED, 32'd1);
    add_step(1'b0, '0);
    add_set(32'h0007_0000, 32'h0008_0000, 32'h0001_0000, 32'h0001_0000);
    add_step(1'b1, '{32'h0007_0000, 32'h0008_0000, 32'h0, 32'h0});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == ROW_REG) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        push_item(row.cmd, row.px, row.py, row.vx, row.vy, row.typed, row.exp);
      end
    end

    // random phases: new settings once idle, then set/step runs with some noise
    total = 0;
    while (total < RANDOM_ITEMS) begin
      wait_idle();
      pin = ($urandom_range(0, 7) == 0);
      write_reg(vpbs_pkg::CFG_FRICTION, pick_gain());
      write_reg(vpbs_pkg::CFG_BOUNCE, pick_gain());
      write_reg(vpbs_pkg::CFG_GRAVITY, pick_gravity());
      write_reg(vpbs_pkg::CFG_WIDTH, pick_span());
      write_reg(vpbs_pkg::CFG_HEIGHT, pick_span());
      write_reg(vpbs_pkg::CFG_PINNED, ($urandom & 32'hFFFF_FFFE) | 32'(pin));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) == 1 ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
      in_gap_max = pick_idle();
      out_stall_max = pick_idle();
      n = $urandom_range(40, 120);
      sent = 0;
      while (sent < n) begin
        if ($urandom_range(0, 9) == 0) begin
          push_item($urandom_range(0, 1) == 1 ? vpbs_pkg::CMD_STEP : vpbs_pkg::CMD_SET,
                    $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
          sent++;
        end else begin
          push_item(vpbs_pkg::CMD_SET, rand_coord(span_w), rand_coord(span_h),
                    rand_vel(), rand_vel(), 1'b0, '0);
          k = $urandom_range(1, 25);
          repeat (k) push_item(vpbs_pkg::CMD_STEP, $urandom, $urandom, $urandom, $urandom,
                               1'b0, '0);
          sent += k + 1;
        end
      end
      total += sent;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("verlet_point_bounded_step regression: pass");
    end else begin
      $display("verlet_point_bounded_step regression: fail");
    end
    $finish;
  end

endmodule
